FILE: src/qtbd_pkg.sv
// ----------------------------------------------------------------------------
// qtbd_pkg
// Shared constants and helpers for the quadtree bilevel decoder.
// ----------------------------------------------------------------------------
package qtbd_pkg;

    localparam int TILE_SIZE_DEF = 64;
    localparam int MAX_TILES     = 1024;
    localparam int PATH_SLOTS    = 8;

    localparam int TILE_IDX_W = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CLAMP_W    = 13;
    localparam int PIX_W      = 16;
    localparam int SIZE_W     = 3;
    localparam int CORNER_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = CFG_IDX_W'(1);

    localparam logic [1:0] QUAD_LAST = 2'd3;

    // Smallest k with 2^k >= tile size, capped at the path depth.
    function automatic int tile_log(input int tile_size);
        int k;
        k = 0;
        while (k < PATH_SLOTS && (1 << k) < tile_size) begin
            k = k + 1;
        end
        return k;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] clamp_tiles(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_DATA_W'(1);
        end else if (CLAMP_W'(v) > CLAMP_W'(MAX_TILES)) begin
            r = CFG_DATA_W'(MAX_TILES);
        end
        return r;
    endfunction

endpackage

FILE: src/quadtree_bilevel_decoder_unit.sv
// ----------------------------------------------------------------------------
// quadtree_bilevel_decoder_unit
// Decodes a quadtree bilevel bitstream, one bit per item, into fill commands.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | stream_bit, frame_start
//   m_      | out       | m_valid / m_ready  | pixel_col, pixel_row, size_log,
//           |           |                    | fill_color, image_done
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data
//
// One item per cycle while s_ready is high; each fill command is registered.
// Tree position and tile counters update in the cycle an item is accepted.
// The result register holds a command until taken; s_ready stays high while
// that register is empty or being drained in the same cycle.
// Synchronous active-low reset clears tree state, counters and m_valid.
// ----------------------------------------------------------------------------
module quadtree_bilevel_decoder_unit
    import qtbd_pkg::*;
#(
    parameter int TILE_SIZE = TILE_SIZE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_stream_bit,
    input  logic                  s_frame_start,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_pixel_col,
    output logic [PIX_W-1:0]      m_pixel_row,
    output logic [SIZE_W-1:0]     m_size_log,
    output logic                  m_fill_color,
    output logic                  m_image_done
);

    localparam int TLOG  = tile_log(TILE_SIZE);
    localparam int LVL_W = $clog2(TLOG + 1);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(TLOG);

    logic [CFG_DATA_W-1:0] tiles_across_reg;
    logic [CFG_DATA_W-1:0] tiles_down_reg;

    logic [LVL_W-1:0]      level_reg,   level_next;
    logic [1:0]            path_reg    [TLOG];
    logic [1:0]            path_next   [TLOG];
    logic                  expect_reg,  expect_next;
    logic [TILE_IDX_W-1:0] tile_col_reg, tile_col_next;
    logic [TILE_IDX_W-1:0] tile_row_reg, tile_row_next;
    logic                  finished_reg, finished_next;

    logic                  m_valid_reg;
    logic [PIX_W-1:0]      pixel_col_reg,  pixel_col_next;
    logic [PIX_W-1:0]      pixel_row_reg,  pixel_row_next;
    logic [SIZE_W-1:0]     size_log_reg,   size_log_next;
    logic                  fill_color_reg;
    logic                  image_done_reg, image_done_next;

    logic                  emit;
    logic                  accept;

    logic [LVL_W-1:0]      cur_level;
    logic [1:0]            cur_path [TLOG];
    logic                  cur_expect;
    logic [TILE_IDX_W-1:0] cur_tcol;
    logic [TILE_IDX_W-1:0] cur_trow;
    logic                  cur_fin;

    logic [LVL_W-1:0]      lvl;
    logic [TLOG-1:0]       col_off;
    logic [TLOG-1:0]       row_off;
    logic [CORNER_W-1:0]   col_full;
    logic [CORNER_W-1:0]   row_full;
    logic                  up_found;
    logic [LVL_W-1:0]      up_idx;
    logic [CFG_DATA_W-1:0] across;
    logic [CFG_DATA_W-1:0] down;
    logic [LVL_W:0]        slog_wide;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign across  = clamp_tiles(tiles_across_reg);
    assign down    = clamp_tiles(tiles_down_reg);

    // restart before use when frame_start is set
    always_comb begin
        if (s_frame_start) begin
            cur_level  = '0;
            cur_expect = 1'b0;
            cur_tcol   = '0;
            cur_trow   = '0;
            cur_fin    = 1'b0;
            for (int i = 0; i < TLOG; i++) begin
                cur_path[i] = 2'd0;
            end
        end else begin
            cur_level  = level_reg;
            cur_expect = expect_reg;
            cur_tcol   = tile_col_reg;
            cur_trow   = tile_row_reg;
            cur_fin    = finished_reg;
            for (int i = 0; i < TLOG; i++) begin
                cur_path[i] = path_reg[i];
            end
        end
    end

    assign lvl       = (cur_level > LVL_MAX) ? LVL_MAX : cur_level;
    assign slog_wide = (LVL_W + 1)'(LVL_MAX) - (LVL_W + 1)'(lvl);

    always_comb begin
        for (int i = 0; i < TLOG; i++) begin
            col_off[TLOG-1-i] = (LVL_W'(i) < lvl) && cur_path[i][0];
            row_off[TLOG-1-i] = (LVL_W'(i) < lvl) && cur_path[i][1];
        end
    end

    assign col_full = CORNER_W'(cur_tcol) * CORNER_W'(TILE_SIZE) + CORNER_W'(col_off);
    assign row_full = CORNER_W'(cur_trow) * CORNER_W'(TILE_SIZE) + CORNER_W'(row_off);

    // deepest level on the path that still has a sibling to visit
    always_comb begin
        up_found = 1'b0;
        up_idx   = '0;
        for (int i = 0; i < TLOG; i++) begin
            if ((LVL_W'(i) < lvl) && (cur_path[i] != QUAD_LAST)) begin
                up_found = 1'b1;
                up_idx   = LVL_W'(i);
            end
        end
    end

    always_comb begin
        level_next      = cur_level;
        expect_next     = cur_expect;
        tile_col_next   = cur_tcol;
        tile_row_next   = cur_trow;
        finished_next   = cur_fin;
        image_done_next = 1'b0;
        emit            = 1'b0;
        for (int i = 0; i < TLOG; i++) begin
            path_next[i] = cur_path[i];
        end

        if (!cur_fin) begin
            if (!cur_expect && (lvl != LVL_MAX)) begin
                if (s_stream_bit) begin
                    expect_next = 1'b1;
                end else begin
                    for (int i = 0; i < TLOG; i++) begin
                        if (LVL_W'(i) == lvl) begin
                            path_next[i] = 2'd0;
                        end
                    end
                    level_next = lvl + LVL_W'(1);
                end
            end else begin
                emit        = 1'b1;
                expect_next = 1'b0;
                if (up_found) begin
                    for (int i = 0; i < TLOG; i++) begin
                        if (LVL_W'(i) == up_idx) begin
                            path_next[i] = cur_path[i] + 2'd1;
                        end
                    end
                    level_next = up_idx + LVL_W'(1);
                end else begin
                    level_next = '0;
                    for (int i = 0; i < TLOG; i++) begin
                        path_next[i] = 2'd0;
                    end
                    if ((CFG_DATA_W'(cur_tcol) + CFG_DATA_W'(1)) >= across) begin
                        tile_col_next = '0;
                        if ((CFG_DATA_W'(cur_trow) + CFG_DATA_W'(1)) >= down) begin
                            finished_next   = 1'b1;
                            image_done_next = 1'b1;
                            tile_row_next   = '0;
                        end else begin
                            tile_row_next = cur_trow + TILE_IDX_W'(1);
                        end
                    end else begin
                        tile_col_next = cur_tcol + TILE_IDX_W'(1);
                    end
                end
            end
        end
    end

    assign pixel_col_next = col_full[PIX_W-1:0];
    assign pixel_row_next = row_full[PIX_W-1:0];
    assign size_log_next  = slog_wide[SIZE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiles_across_reg <= CFG_DATA_W'(1);
            tiles_down_reg   <= CFG_DATA_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TILES_ACROSS: tiles_across_reg <= cfg_data;
                REG_TILES_DOWN:   tiles_down_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            expect_reg   <= 1'b0;
            tile_col_reg <= '0;
            tile_row_reg <= '0;
            finished_reg <= 1'b0;
            for (int i = 0; i < TLOG; i++) begin
                path_reg[i] <= 2'd0;
            end
        end else if (accept) begin
            level_reg    <= level_next;
            expect_reg   <= expect_next;
            tile_col_reg <= tile_col_next;
            tile_row_reg <= tile_row_next;
            finished_reg <= finished_next;
            for (int i = 0; i < TLOG; i++) begin
                path_reg[i] <= path_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            pixel_col_reg  <= pixel_col_next;
            pixel_row_reg  <= pixel_row_next;
            size_log_reg   <= size_log_next;
            fill_color_reg <= s_stream_bit;
            image_done_reg <= image_done_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_col  = pixel_col_reg;
    assign m_pixel_row  = pixel_row_reg;
    assign m_size_log   = size_log_reg;
    assign m_fill_color = fill_color_reg;
    assign m_image_done = image_done_reg;

endmodule
